### sv/spd_pkg.sv
// shared types, constants and helpers for the sensor packet deframer
`timescale 1ns / 1ps

package spd_pkg;

    // counter width, saturating at all ones
    localparam int COUNT_BITS = 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // packet layout
    localparam int POS_W   = 5;
    localparam int HDR_LEN = 4;
    localparam int SUM_END = 20;
    localparam int PAYLOAD_BYTES = SUM_END - HDR_LEN;

    // header reset values ("snp" plus terminator)
    localparam logic [7:0] HDR_FIRST_RST  = 8'd115;
    localparam logic [7:0] HDR_SECOND_RST = 8'd110;
    localparam logic [7:0] HDR_THIRD_RST  = 8'd112;
    localparam logic [7:0] HDR_FOURTH_RST = 8'd0;

    // configuration register indexes
    localparam logic [1:0] REG_HEADER_FIRST  = 2'd0;
    localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
    localparam logic [1:0] REG_HEADER_THIRD  = 2'd2;
    localparam logic [1:0] REG_HEADER_FOURTH = 2'd3;

    // command codes
    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // status codes
    localparam logic [2:0] STATUS_BYTE    = 3'd0;
    localparam logic [2:0] STATUS_GOOD    = 3'd1;
    localparam logic [2:0] STATUS_BAD_SUM = 3'd2;
    localparam logic [2:0] STATUS_ABORT   = 3'd3;
    localparam logic [2:0] STATUS_CLEARED = 3'd4;

    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] first_word;
        logic [31:0] second_word;
        logic [31:0] third_word;
        logic [31:0] uptime_word;
        logic [15:0] good_count;
        logic [15:0] aborted_count;
        logic [15:0] bad_checksum_count;
    } out_item_t;

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
        logic [7:0] third;
        logic [7:0] fourth;
    } hdr_cfg_t;

    function automatic count_t bump(input count_t c);
        bump = (c == COUNT_MAX) ? c : c + count_t'(1);
    endfunction

endpackage

### sv/spd_core.sv
// framing state, checksum, payload bytes and packet counters
`timescale 1ns / 1ps

module spd_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  spd_pkg::in_item_t  item,
    input  spd_pkg::hdr_cfg_t  hdr,
    output spd_pkg::out_item_t result
);

    logic [spd_pkg::POS_W-1:0] pos_reg, pos_next, pos_eff;
    logic [15:0]               sum_reg, sum_next;
    logic [7:0]                chk_high_reg, chk_high_next;
    spd_pkg::count_t           good_reg, good_next;
    spd_pkg::count_t           abort_reg, abort_next;
    spd_pkg::count_t           bad_reg, bad_next;
    logic [7:0]                store_reg [spd_pkg::PAYLOAD_BYTES];
    logic                      store_we;
    logic [3:0]                store_idx;
    logic [7:0]                expected;
    logic [2:0]                status;
    logic                      good_pkt;
    logic [7:0]                b;
    logic                      resync;

    assign b = item.data_byte;

    // resync byte mid-packet restarts framing at this byte
    assign resync  = (b == hdr.first) && (pos_reg != '0);
    assign pos_eff = resync ? '0 : pos_reg;

    always_comb begin
        case (pos_eff[1:0])
            2'd0:    expected = hdr.first;
            2'd1:    expected = hdr.second;
            2'd2:    expected = hdr.third;
            default: expected = hdr.fourth;
        endcase
    end

    always_comb begin
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        chk_high_next = chk_high_reg;
        good_next     = good_reg;
        abort_next    = abort_reg;
        bad_next      = bad_reg;
        store_we      = 1'b0;
        store_idx     = 4'(pos_reg - spd_pkg::POS_W'(spd_pkg::HDR_LEN));
        status        = spd_pkg::STATUS_BYTE;
        good_pkt      = 1'b0;
        if (item.cmd == spd_pkg::CMD_CLEAR) begin
            good_next  = '0;
            abort_next = '0;
            bad_next   = '0;
            status     = spd_pkg::STATUS_CLEARED;
        end else begin
            if (resync) begin
                abort_next = spd_pkg::bump(abort_reg);
                status     = spd_pkg::STATUS_ABORT;
            end
            if (pos_eff < spd_pkg::POS_W'(spd_pkg::HDR_LEN)) begin
                if (b == expected) begin
                    sum_next = (pos_eff == '0) ? {8'd0, b} : sum_reg + {8'd0, b};
                    pos_next = pos_eff + 1'b1;
                end else begin
                    pos_next   = '0;
                    sum_next   = '0;
                    abort_next = spd_pkg::bump(abort_reg);
                    status     = spd_pkg::STATUS_ABORT;
                end
            end else if (pos_eff < spd_pkg::POS_W'(spd_pkg::SUM_END)) begin
                store_we = 1'b1;
                sum_next = sum_reg + {8'd0, b};
                pos_next = pos_eff + 1'b1;
            end else if (pos_eff == spd_pkg::POS_W'(spd_pkg::SUM_END)) begin
                chk_high_next = b;
                pos_next      = pos_eff + 1'b1;
            end else begin
                if ({chk_high_reg, b} == sum_reg) begin
                    good_pkt  = 1'b1;
                    good_next = spd_pkg::bump(good_reg);
                    status    = spd_pkg::STATUS_GOOD;
                end else begin
                    bad_next = spd_pkg::bump(bad_reg);
                    status   = spd_pkg::STATUS_BAD_SUM;
                end
                pos_next = '0;
                sum_next = '0;
            end
        end
    end

    always_comb begin
        result                    = '0;
        result.status             = status;
        result.good_count         = 16'(good_next);
        result.aborted_count      = 16'(abort_next);
        result.bad_checksum_count = 16'(bad_next);
        if (good_pkt) begin
            result.first_word  = {store_reg[3], store_reg[2], store_reg[1], store_reg[0]};
            result.second_word = {store_reg[7], store_reg[6], store_reg[5], store_reg[4]};
            result.third_word  = {store_reg[11], store_reg[10], store_reg[9], store_reg[8]};
            result.uptime_word = {store_reg[15], store_reg[14], store_reg[13], store_reg[12]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            sum_reg   <= '0;
            good_reg  <= '0;
            abort_reg <= '0;
            bad_reg   <= '0;
        end else if (fire) begin
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            good_reg  <= good_next;
            abort_reg <= abort_next;
            bad_reg   <= bad_next;
        end
    end

    // payload bytes and checksum high byte need no reset
    always_ff @(posedge aclk) begin
        if (fire) begin
            chk_high_reg <= chk_high_next;
            if (store_we) begin
                store_reg[store_idx] <= b;
            end
        end
    end

endmodule

### sv/sensor_packet_deframer.sv
// top level: input register, deframer core, result register, header registers
`timescale 1ns / 1ps
// path: an item transferred on s_ passes the input register and then the
// result register before m_valid rises and its result can transfer on m_
// throughput: one item per cycle while the result register frees; the core updates framing state in one pass
// the result register frees whenever m_ready is high or it is empty
// reset (aresetn low, synchronous) clears position, running sum, counters,
// both valid flags and restores the header bytes to "snp" plus zero

module sensor_packet_deframer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  spd_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output spd_pkg::out_item_t m_data,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    spd_pkg::in_item_t  in_reg;
    logic               in_valid_reg;
    spd_pkg::out_item_t out_reg;
    logic               out_valid_reg;
    spd_pkg::out_item_t result;
    spd_pkg::hdr_cfg_t  hdr_reg;
    logic               advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg.first  <= spd_pkg::HDR_FIRST_RST;
            hdr_reg.second <= spd_pkg::HDR_SECOND_RST;
            hdr_reg.third  <= spd_pkg::HDR_THIRD_RST;
            hdr_reg.fourth <= spd_pkg::HDR_FOURTH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                spd_pkg::REG_HEADER_FIRST:  hdr_reg.first  <= cfg_data;
                spd_pkg::REG_HEADER_SECOND: hdr_reg.second <= cfg_data;
                spd_pkg::REG_HEADER_THIRD:  hdr_reg.third  <= cfg_data;
                spd_pkg::REG_HEADER_FOURTH: hdr_reg.fourth <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    spd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .item    (in_reg),
        .hdr     (hdr_reg),
        .result  (result)
    );

endmodule

### sim/tb_sensor_packet_deframer.sv
// self-checking testbench for the sensor packet deframer
`timescale 1ns / 1ps

module tb_sensor_packet_deframer;

    localparam int CYCLE_LIMIT = 100000;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASE_ITEMS = 95;

    typedef struct {
        spd_pkg::in_item_t  item;
        bit                 typed;
        spd_pkg::out_item_t result;
    } stim_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    spd_pkg::in_item_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    spd_pkg::out_item_t m_data;
    logic               cfg_wr_en = 1'b0;
    logic [1:0]         cfg_index = spd_pkg::REG_HEADER_FIRST;
    logic [7:0]         cfg_data = '0;

    // deframer image: header settings, framing state and counters
    spd_pkg::hdr_cfg_t cur_hdr;
    logic [4:0]        frame_pos;
    logic [15:0]       frame_sum;
    logic [7:0]        payload_bytes [spd_pkg::PAYLOAD_BYTES];
    logic [7:0]        sum_high;
    spd_pkg::count_t   good_total, aborted_total, bad_total;

    spd_pkg::out_item_t pending_results [$];
    stim_row_t          stim_rows [$];

    int send_idle_pct = 30;
    int recv_idle_pct = 54;
    int hold_asks = 0;
    int hold_done = 0;
    int hold_left = 0;
    int cycles = 0;
    int mismatches = 0;
    int transfers_in = 0;
    int results_checked = 0;
    int header_settings = 1;
    int status_seen [8] = '{default: 0};

    sensor_packet_deframer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic spd_pkg::count_t sat_inc(input spd_pkg::count_t c);
        return (c == spd_pkg::COUNT_MAX) ? c : c + spd_pkg::count_t'(1);
    endfunction

    function automatic logic [7:0] header_byte(input int idx);
        case (idx % spd_pkg::HDR_LEN)
            0: return cur_hdr.first;
            1: return cur_hdr.second;
            2: return cur_hdr.third;
            default: return cur_hdr.fourth;
        endcase
    endfunction

    function automatic spd_pkg::in_item_t byte_item(input logic [7:0] b);
        spd_pkg::in_item_t it;
        it.cmd = spd_pkg::CMD_BYTE;
        it.data_byte = b;
        return it;
    endfunction

    function automatic spd_pkg::in_item_t clear_item(input logic [7:0] b);
        spd_pkg::in_item_t it;
        it.cmd = spd_pkg::CMD_CLEAR;
        it.data_byte = b;
        return it;
    endfunction

    function automatic spd_pkg::out_item_t counts_only(input logic [2:0] st, input int g,
                                                       input int a, input int bd);
        spd_pkg::out_item_t r;
        r = '0;
        r.status = st;
        r.good_count = 16'(g);
        r.aborted_count = 16'(a);
        r.bad_checksum_count = 16'(bd);
        return r;
    endfunction

    // advance the deframer image by one transfer and return its result
    function automatic spd_pkg::out_item_t deframe_step(input spd_pkg::in_item_t it);
        spd_pkg::out_item_t r;
        logic [7:0] b;
        r = '0;
        b = it.data_byte;
        if (it.cmd == spd_pkg::CMD_CLEAR) begin
            good_total = '0;
            aborted_total = '0;
            bad_total = '0;
            r.status = spd_pkg::STATUS_CLEARED;
        end else begin
            // header_first anywhere inside a packet restarts framing on this byte
            if (b == cur_hdr.first && frame_pos != 0) begin
                frame_pos = '0;
                aborted_total = sat_inc(aborted_total);
                r.status = spd_pkg::STATUS_ABORT;
            end
            if (frame_pos < spd_pkg::HDR_LEN) begin
                if (b == header_byte(frame_pos)) begin
                    frame_sum = (frame_pos == 0) ? {8'h00, b} : frame_sum + b;
                    frame_pos = frame_pos + 1'b1;
                end else begin
                    frame_pos = '0;
                    frame_sum = '0;
                    aborted_total = sat_inc(aborted_total);
                    r.status = spd_pkg::STATUS_ABORT;
                end
            end else if (frame_pos < spd_pkg::SUM_END) begin
                payload_bytes[frame_pos - spd_pkg::HDR_LEN] = b;
                frame_sum = frame_sum + b;
                frame_pos = frame_pos + 1'b1;
            end else if (frame_pos == spd_pkg::SUM_END) begin
                sum_high = b;
                frame_pos = frame_pos + 1'b1;
            end else begin
                if ({sum_high, b} == frame_sum) begin
                    r.first_word  = {payload_bytes[3], payload_bytes[2],
                                     payload_bytes[1], payload_bytes[0]};
                    r.second_word = {payload_bytes[7], payload_bytes[6],
                                     payload_bytes[5], payload_bytes[4]};
                    r.third_word  = {payload_bytes[11], payload_bytes[10],
                                     payload_bytes[9], payload_bytes[8]};
                    r.uptime_word = {payload_bytes[15], payload_bytes[14],
                                     payload_bytes[13], payload_bytes[12]};
                    good_total = sat_inc(good_total);
                    r.status = spd_pkg::STATUS_GOOD;
                end else begin
                    bad_total = sat_inc(bad_total);
                    r.status = spd_pkg::STATUS_BAD_SUM;
                end
                frame_pos = '0;
                frame_sum = '0;
            end
        end
        r.good_count = good_total[15:0];
        r.aborted_count = aborted_total[15:0];
        r.bad_checksum_count = bad_total[15:0];
        return r;
    endfunction

    task automatic check_result(input spd_pkg::out_item_t exp, input spd_pkg::out_item_t got);
        if (got.status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, got.status);
            mismatches++;
        end
        if (got.first_word !== exp.first_word) begin
            $error("first_word: expected %h, got %h", exp.first_word, got.first_word);
            mismatches++;
        end
        if (got.second_word !== exp.second_word) begin
            $error("second_word: expected %h, got %h", exp.second_word, got.second_word);
            mismatches++;
        end
        if (got.third_word !== exp.third_word) begin
            $error("third_word: expected %h, got %h", exp.third_word, got.third_word);
            mismatches++;
        end
        if (got.uptime_word !== exp.uptime_word) begin
            $error("uptime_word: expected %h, got %h", exp.uptime_word, got.uptime_word);
            mismatches++;
        end
        if (got.good_count !== exp.good_count) begin
            $error("good_count: expected %0d, got %0d", exp.good_count, got.good_count);
            mismatches++;
        end
        if (got.aborted_count !== exp.aborted_count) begin
            $error("aborted_count: expected %0d, got %0d",
                   exp.aborted_count, got.aborted_count);
            mismatches++;
        end
        if (got.bad_checksum_count !== exp.bad_checksum_count) begin
            $error("bad_checksum_count: expected %0d, got %0d",
                   exp.bad_checksum_count, got.bad_checksum_count);
            mismatches++;
        end
    endtask

    // result side: compare every transfer against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no expectation waiting, status %0d",
                       m_data.status);
                mismatches++;
            end else begin
                check_result(pending_results.pop_front(), m_data);
            end
            results_checked++;
            status_seen[m_data.status]++;
        end
    end

    // receiver readiness, with a long hold-off on request
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_done != hold_asks) begin
            m_ready <= 1'b0;
            hold_done <= hold_done + 1;
            hold_left <= HOLD_CYCLES;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic offer(input spd_pkg::in_item_t it, input bit typed,
                         input spd_pkg::out_item_t typed_result);
        spd_pkg::out_item_t predicted;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        predicted = deframe_step(it);
        pending_results.push_back(typed ? typed_result : predicted);
        transfers_in++;
    endtask

    task automatic drain;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    task automatic write_headers(input spd_pkg::hdr_cfg_t h);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= spd_pkg::REG_HEADER_FIRST;
        cfg_data <= h.first;
        @(negedge aclk);
        cfg_index <= spd_pkg::REG_HEADER_SECOND;
        cfg_data <= h.second;
        @(negedge aclk);
        cfg_index <= spd_pkg::REG_HEADER_THIRD;
        cfg_data <= h.third;
        @(negedge aclk);
        cfg_index <= spd_pkg::REG_HEADER_FOURTH;
        cfg_data <= h.fourth;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cur_hdr = h;
    endtask

    // one packet-shaped burst: mostly well-formed packets, the rest broken, noise or a clear
    task automatic send_packet;
        logic [7:0] pkt [22];
        logic [15:0] sum;
        logic [7:0] v;
        int kind, n, i;
        sum = '0;
        for (i = 0; i < spd_pkg::SUM_END; i++) begin
            if (i < spd_pkg::HDR_LEN) begin
                v = header_byte(i);
            end else begin
                v = 8'($urandom_range(255));
                if (v == cur_hdr.first)
                    v = v ^ 8'h01;
            end
            pkt[i] = v;
            sum = sum + v;
        end
        pkt[20] = sum[15:8];
        pkt[21] = sum[7:0];
        kind = $urandom_range(99);
        if (kind < 72) begin
            // good, or checksum broken in the low byte
            if (kind >= 60)
                pkt[21] = pkt[21] ^ 8'($urandom_range(1, 255));
            for (i = 0; i < 22; i++)
                offer(byte_item(pkt[i]), 1'b0, '0);
        end else if (kind < 80) begin
            // cut short; later bytes resync, abort or run on as payload
            n = $urandom_range(1, 20);
            for (i = 0; i < n; i++)
                offer(byte_item(pkt[i]), 1'b0, '0);
        end else if (kind < 88) begin
            n = $urandom_range(0, 3);
            for (i = 0; i < n; i++)
                offer(byte_item(pkt[i]), 1'b0, '0);
            do v = 8'($urandom_range(255));
            while (v == header_byte(n) || v == cur_hdr.first);
            offer(byte_item(v), 1'b0, '0);
        end else if (kind < 96) begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++)
                offer(byte_item(8'($urandom_range(255))), 1'b0, '0);
        end else begin
            offer(clear_item(8'($urandom_range(255))), 1'b0, '0);
        end
    endtask

    task automatic run_phase(input spd_pkg::hdr_cfg_t h, input bit hold);
        int target;
        write_headers(h);
        header_settings++;
        if (hold)
            hold_asks++;
        target = transfers_in + PHASE_ITEMS;
        while (transfers_in < target)
            send_packet();
    endtask

    task automatic add_row(input spd_pkg::in_item_t it, input bit typed,
                           input spd_pkg::out_item_t r);
        stim_row_t row;
        row.item = it;
        row.typed = typed;
        row.result = r;
        stim_rows.push_back(row);
    endtask

    initial begin
        spd_pkg::hdr_cfg_t default_hdr, h;
        spd_pkg::out_item_t good_row;
        int i;

        default_hdr.first = spd_pkg::HDR_FIRST_RST;
        default_hdr.second = spd_pkg::HDR_SECOND_RST;
        default_hdr.third = spd_pkg::HDR_THIRD_RST;
        default_hdr.fourth = spd_pkg::HDR_FOURTH_RST;
        cur_hdr = default_hdr;
        frame_pos = '0;
        frame_sum = '0;
        sum_high = '0;
        good_total = '0;
        aborted_total = '0;
        bad_total = '0;
        for (i = 0; i < spd_pkg::PAYLOAD_BYTES; i++)
            payload_bytes[i] = '0;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // idle garbage, clear, resync on a repeated first byte, then one good packet
        add_row(byte_item(8'h00), 1'b1, counts_only(spd_pkg::STATUS_ABORT, 0, 1, 0));
        add_row(byte_item(8'hFF), 1'b1, counts_only(spd_pkg::STATUS_ABORT, 0, 2, 0));
        add_row(clear_item(8'hFF), 1'b1, counts_only(spd_pkg::STATUS_CLEARED, 0, 0, 0));
        add_row(byte_item(spd_pkg::HDR_FIRST_RST), 1'b1,
                counts_only(spd_pkg::STATUS_BYTE, 0, 0, 0));
        add_row(byte_item(spd_pkg::HDR_FIRST_RST), 1'b1,
                counts_only(spd_pkg::STATUS_ABORT, 0, 1, 0));
        add_row(byte_item(spd_pkg::HDR_SECOND_RST), 1'b0, '0);
        add_row(byte_item(spd_pkg::HDR_THIRD_RST), 1'b0, '0);
        add_row(byte_item(spd_pkg::HDR_FOURTH_RST), 1'b0, '0);
        for (i = 0; i < spd_pkg::PAYLOAD_BYTES; i++)
            add_row(byte_item((i < 8) ? 8'hFF : 8'h00), 1'b0, '0);
        // "snp" + 0 + eight 0xff bytes sums to 0x0949
        add_row(byte_item(8'h09), 1'b0, '0);
        good_row = counts_only(spd_pkg::STATUS_GOOD, 1, 1, 0);
        good_row.first_word = 32'hFFFF_FFFF;
        good_row.second_word = 32'hFFFF_FFFF;
        add_row(byte_item(8'h49), 1'b1, good_row);

        foreach (stim_rows[k])
            offer(stim_rows[k].item, stim_rows[k].typed, stim_rows[k].result);

        run_phase(default_hdr, 1'b0);
        run_phase('{first: 8'h00, second: 8'hFF, third: 8'h80, fourth: 8'h7F}, 1'b0);

        send_idle_pct = 54;
        recv_idle_pct = 30;
        run_phase('{first: 8'hFF, second: 8'h00, third: 8'h01, fourth: 8'hFE}, 1'b0);
        h = spd_pkg::hdr_cfg_t'($urandom);
        run_phase(h, 1'b0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        h = spd_pkg::hdr_cfg_t'($urandom);
        run_phase(h, 1'b1);
        run_phase(default_hdr, 1'b0);

        drain();
        repeat (8) @(posedge aclk);

        $display("checked %0d results from %0d transfers over %0d header settings",
                 results_checked, transfers_in, header_settings);
        $display("status mix: %0d good, %0d checksum errors, %0d aborts, %0d clears, %0d bytes",
                 status_seen[spd_pkg::STATUS_GOOD], status_seen[spd_pkg::STATUS_BAD_SUM],
                 status_seen[spd_pkg::STATUS_ABORT], status_seen[spd_pkg::STATUS_CLEARED],
                 status_seen[spd_pkg::STATUS_BYTE]);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
